// ===== rtl/gtl_pkg.sv =====
package gtl_pkg;

    // Coordinate width of cursor and origin
    localparam int C_COORD_W = 16;
    localparam int C_QDEPTH  = 4;
    localparam int C_QPTR_W  = $clog2(C_QDEPTH);
    localparam int C_QCNT_W  = $clog2(C_QDEPTH + 1);

    // Configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] REG_BOX_WIDTH  = 3'd2;
    localparam logic [2:0] REG_BOX_HEIGHT = 3'd3;
    localparam logic [2:0] REG_FONT_SIZE  = 3'd4;

    // Byte codes
    localparam logic [7:0] BYTE_END      = 8'h00;
    localparam logic [7:0] BYTE_CR       = 8'd13;
    localparam logic [7:0] BYTE_ASCII_HI = 8'h80;
    localparam logic [7:0] BYTE_INVALID  = 8'hff;
    localparam logic [7:0] TRAIL_LOW     = 8'h40;
    localparam logic [7:0] TRAIL_GAP     = 8'h7f;
    localparam logic [7:0] TRAIL_HIGH    = 8'h41;
    localparam logic [7:0] LEAD_BASE     = 8'h81;
    localparam logic [7:0] ROW_STRIDE    = 8'd190;

    typedef enum logic [1:0] {
        KIND_ASCII = 2'd0,
        KIND_HANZI = 2'd1,
        KIND_BLANK = 2'd2
    } t_kind;

    // Draw command passed from front to back
    typedef struct packed {
        t_kind                  kind;
        logic [C_COORD_W-1:0]   pos_x;
        logic [C_COORD_W-1:0]   pos_y;
        logic [7:0]             char_code;
        logic [6:0]             row;
        logic [7:0]             col;
        logic [6:0]             glyph_bytes;
    } t_cmd;

endpackage

// ===== rtl/gtl_front.sv =====
module gtl_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_s_tvalid,
    input  logic [7:0]          i_s_tdata,
    input  logic                i_q_space,
    output logic                o_s_tready,
    output logic                o_push,
    output gtl_pkg::t_cmd       o_cmd
);

    localparam int CW = gtl_pkg::C_COORD_W;

    logic [15:0]        r_origin_x, r_origin_y, r_box_w, r_box_h;
    logic [7:0]         r_font;
    logic               r_settle;

    // Derived limits, refreshed every cycle from the registers
    logic signed [17:0] r_lim_half, r_lim_full, r_lim_y;
    logic [CW-1:0]      r_half, r_cr_x;
    logic [6:0]         r_gbytes;
    logic               r_fs_ok;

    logic [CW-1:0]      r_cx, r_cy, n_cx, n_cy;
    logic               r_lead, n_lead, r_skip, n_skip, r_stop, n_stop;
    logic [7:0]         r_lead_byte, n_lead_byte;

    logic               w_acc, w_wrap, w_over, w_blank;
    logic signed [17:0] w_wrap_lim;
    logic [CW-1:0]      w_fs, w_cy_inc, w_x1, w_y1, w_adv;
    logic [7:0]         w_b, w_col;
    logic [6:0]         w_row;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= 16'd0;
            r_origin_y <= 16'd0;
            r_box_w    <= 16'd240;
            r_box_h    <= 16'd320;
            r_font     <= 8'd16;
            r_settle   <= 1'b1;
        end else begin
            r_settle <= i_cfg_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gtl_pkg::REG_ORIGIN_X:   r_origin_x <= i_cfg_data;
                    gtl_pkg::REG_ORIGIN_Y:   r_origin_y <= i_cfg_data;
                    gtl_pkg::REG_BOX_WIDTH:  r_box_w    <= i_cfg_data;
                    gtl_pkg::REG_BOX_HEIGHT: r_box_h    <= i_cfg_data;
                    gtl_pkg::REG_FONT_SIZE:  r_font     <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Precompute wrap and height limits, carriage-return x and glyph size
    always_ff @(posedge i_clk) begin
        r_half     <= {{(CW-7){1'b0}}, r_font[7:1]};
        r_lim_half <= $signed({2'b00, r_origin_x} + {2'b00, r_box_w} - {11'd0, r_font[7:1]});
        r_lim_full <= $signed({2'b00, r_origin_x} + {2'b00, r_box_w} - {10'd0, r_font});
        r_lim_y    <= $signed({2'b00, r_origin_y} + {2'b00, r_box_h} - {10'd0, r_font});
        r_cr_x     <= r_origin_x + {{(CW-7){1'b0}}, r_font[7:1]};
        case (r_font)
            8'd12:   begin r_gbytes <= 7'd24; r_fs_ok <= 1'b1; end
            8'd16:   begin r_gbytes <= 7'd32; r_fs_ok <= 1'b1; end
            8'd24:   begin r_gbytes <= 7'd72; r_fs_ok <= 1'b1; end
            default: begin r_gbytes <= 7'd0;  r_fs_ok <= 1'b0; end
        endcase
    end

    assign o_s_tready = i_q_space && !r_settle;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_b        = i_s_tdata;
    assign w_fs       = {{(CW-8){1'b0}}, r_font};

    // Wrap and height checks
    assign w_wrap_lim = r_lead ? r_lim_full : r_lim_half;
    assign w_adv      = r_lead ? w_fs : r_half;
    assign w_wrap     = $signed({2'b00, r_cx}) > w_wrap_lim;
    assign w_cy_inc   = r_cy + w_fs;
    assign w_x1       = w_wrap ? r_origin_x : r_cx;
    assign w_y1       = w_wrap ? w_cy_inc : r_cy;
    assign w_over     = w_wrap ? ($signed({2'b00, w_cy_inc}) > r_lim_y)
                               : ($signed({2'b00, r_cy}) > r_lim_y);

    // Classify the code pair
    assign w_blank = (r_lead_byte == gtl_pkg::BYTE_INVALID) || (w_b < gtl_pkg::TRAIL_LOW)
                     || (w_b == gtl_pkg::BYTE_INVALID);
    assign w_row   = w_blank ? 7'd0 : 7'(r_lead_byte - gtl_pkg::LEAD_BASE);
    assign w_col   = w_blank ? 8'd0 :
                     (w_b < gtl_pkg::TRAIL_GAP) ? w_b - gtl_pkg::TRAIL_LOW
                                                : w_b - gtl_pkg::TRAIL_HIGH;

    // Next cursor and flags
    always_comb begin
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_lead      = r_lead;
        n_lead_byte = r_lead_byte;
        n_skip      = r_skip;
        n_stop      = r_stop;
        if (w_acc) begin
            if (w_b == gtl_pkg::BYTE_END) begin
                n_cx        = r_origin_x;
                n_cy        = r_origin_y;
                n_lead      = 1'b0;
                n_lead_byte = 8'd0;
                n_skip      = 1'b0;
                n_stop      = 1'b0;
            end else if (r_stop) begin
                n_stop = 1'b1;
            end else if (r_skip) begin
                n_skip = 1'b0;
            end else if (!r_lead && (w_b > gtl_pkg::BYTE_ASCII_HI)) begin
                n_lead      = 1'b1;
                n_lead_byte = w_b;
            end else begin
                n_lead = 1'b0;
                n_cx   = w_x1;
                n_cy   = w_y1;
                if (w_over) begin
                    n_stop = 1'b1;
                end else if (!r_lead && (w_b == gtl_pkg::BYTE_CR)) begin
                    n_cy   = w_y1 + w_fs;
                    n_cx   = r_cr_x;
                    n_skip = 1'b1;
                end else begin
                    n_cx = w_x1 + w_adv;
                end
            end
        end
    end

    // Build the draw command
    always_comb begin
        o_push = 1'b0;
        o_cmd  = '0;
        o_cmd.pos_x = w_x1;
        o_cmd.pos_y = w_y1;
        if (w_acc && (w_b != gtl_pkg::BYTE_END) && !r_stop && !r_skip && !w_over) begin
            if (r_lead) begin
                o_push            = r_fs_ok;
                o_cmd.kind        = w_blank ? gtl_pkg::KIND_BLANK : gtl_pkg::KIND_HANZI;
                o_cmd.row         = w_row;
                o_cmd.col         = w_col;
                o_cmd.glyph_bytes = r_gbytes;
            end else if ((w_b <= gtl_pkg::BYTE_ASCII_HI) && (w_b != gtl_pkg::BYTE_CR)) begin
                o_push          = 1'b1;
                o_cmd.kind      = gtl_pkg::KIND_ASCII;
                o_cmd.char_code = w_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx        <= '0;
            r_cy        <= '0;
            r_lead      <= 1'b0;
            r_lead_byte <= 8'd0;
            r_skip      <= 1'b0;
            r_stop      <= 1'b0;
        end else begin
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_lead      <= n_lead;
            r_lead_byte <= n_lead_byte;
            r_skip      <= n_skip;
            r_stop      <= n_stop;
        end
    end

    // A stopped string places nothing
    a_stop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |-> !o_push)
        else $error("command pushed while string stopped");

    // Nothing is taken in the cycle after a configuration write
    a_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> !o_s_tready)
        else $error("byte taken before limits refreshed");

endmodule

// ===== rtl/gtl_queue.sv =====
module gtl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gtl_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output logic            o_space,
    output logic            o_avail,
    output gtl_pkg::t_cmd   o_cmd
);

    localparam int PW = gtl_pkg::C_QPTR_W;
    localparam int NW = gtl_pkg::C_QCNT_W;

    gtl_pkg::t_cmd  r_slot [gtl_pkg::C_QDEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [NW-1:0]  r_cnt;

    assign o_space = r_cnt != NW'(gtl_pkg::C_QDEPTH);
    assign o_avail = r_cnt != '0;
    assign o_cmd   = r_slot[r_rd];

    // Hold commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_space || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(gtl_pkg::C_QDEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/gtl_back.sv =====
module gtl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_avail,
    input  gtl_pkg::t_cmd   i_cmd,
    input  logic            i_m_tready,
    output logic            o_pop,
    output logic            o_m_tvalid,
    output logic [71:0]     o_m_tdata,
    output logic [1:0]      o_m_tuser
);

    gtl_pkg::t_cmd  r_s1;
    logic           r_s1_valid;
    logic [14:0]    r_idx;
    logic           r_out_valid;
    gtl_pkg::t_kind r_kind;
    logic [15:0]    r_px, r_py;
    logic [7:0]     r_code;
    logic [20:0]    r_off;
    logic [6:0]     r_gb;

    logic           w_adv, w_load_s1;
    logic [21:0]    w_prod;

    assign w_adv     = !r_out_valid || i_m_tready;
    assign w_load_s1 = w_adv || !r_s1_valid;
    assign o_pop     = w_load_s1 && i_avail;
    assign w_prod    = 22'(r_idx) * 22'(r_s1.glyph_bytes);

    // Stage one: glyph index within the table
    always_ff @(posedge i_clk) begin
        if (w_load_s1) begin
            r_s1  <= i_cmd;
            r_idx <= 15'(i_cmd.row) * 15'(gtl_pkg::ROW_STRIDE) + 15'(i_cmd.col);
        end
    end

    // Output register: scale index by glyph size
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_kind <= r_s1.kind;
            r_px   <= r_s1.pos_x;
            r_py   <= r_s1.pos_y;
            r_code <= r_s1.char_code;
            r_gb   <= r_s1.glyph_bytes;
            r_off  <= (r_s1.kind == gtl_pkg::KIND_HANZI) ? w_prod[20:0] : 21'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_s1) begin
                r_s1_valid <= i_avail;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tdata  = {4'd0, r_gb, r_off, r_code, r_py, r_px};

    // A waiting command moves up as soon as the output frees
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_adv) |=> r_out_valid)
        else $error("command lost between stages");

endmodule

// ===== rtl/gbk_text_layout_engine_top.sv =====
// A draw command is queued as its byte is accepted, then registered in stage one and the
// output register. Throughput: one byte per cycle, set by the front's cursor update, while
// the four-entry command queue has space; the queue lets the front run while the output
// is stalled. A configuration write or reset release blocks input until limits refresh.
// Reset (i_rst_n low, synchronous): registers to their defaults, cursor to the origin,
// flags and queue cleared.
module gbk_text_layout_engine_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [7:0]      i_s_tdata,  // [7:0] text_byte
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    // [15:0] pos_x, [31:16] pos_y, [39:32] char_code, [60:40] glyph_offset,
    // [67:61] glyph_bytes, [71:68] zero
    output logic [71:0]     o_m_tdata,
    output logic [1:0]      o_m_tuser   // [1:0] draw_kind
);

    logic           w_space, w_push, w_avail, w_pop;
    gtl_pkg::t_cmd  w_cmd_in, w_cmd_out;

    assign o_cfg_ready = 1'b1;

    gtl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .i_q_space   (w_space),
        .o_s_tready  (o_s_tready),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in)
    );

    gtl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_space (w_space),
        .o_avail (w_avail),
        .o_cmd   (w_cmd_out)
    );

    gtl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (w_avail),
        .i_cmd      (w_cmd_out),
        .i_m_tready (i_m_tready),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
